// ----- src/ebrd_pkg.sv -----
package ebrd_pkg;

  localparam int HISTORY_DEPTH_DEF = 5;
  localparam int SAMPLE_BITS_DEF   = 10;

  localparam int TS_W   = 32;
  localparam int RATE_W = 16;

  localparam int unsigned THR_RESET     = 410;
  localparam int unsigned MS_PER_MINUTE = 60000;
  localparam int unsigned RATE_FRAC     = 16;
  localparam logic [TS_W-1:0] RATE_DIVIDEND = TS_W'(MS_PER_MINUTE * RATE_FRAC);

  typedef struct packed {
    logic cfg_wr;
    logic load;
    logic eval;
    logic span_load;
    logic mul_load;
    logic div_start;
    logic rate_sat;
    logic rate_load;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rate_go;
    logic div_done;
    logic d_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/ecg_beat_rate_detector_core.sv -----
// ECG beat and heart-rate detector. Each input beat is one sample tick (two
// leads-off flags, a sample and a millisecond timestamp) and yields exactly one
// result beat. A tick with either lead off is flagged invalid and leaves all
// state untouched. A sample at or above the threshold register counts a beat
// once, and the detector re-arms when the sample drops below it. Once the
// second-oldest history entry is nonzero, each new heartbeat recomputes the
// rate as 960000 / (span / HISTORY_DEPTH), unsigned Q12.4, saturating at
// 65535. An accepted tick passes through an evaluate and a done state; a tick
// that updates the rate also goes through a reciprocal multiply for span /
// HISTORY_DEPTH and the bit-serial divider, or saturates without dividing
// when the interval is zero. One tick is in work at a time; the output
// register lets the next tick be accepted while a result is stalled. The
// threshold resets to 410 and is written only while no tick is in work.
module ecg_beat_rate_detector_core #(
  parameter int HISTORY_DEPTH = ebrd_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = ebrd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_leads_off_plus,
  input  logic                        in_leads_off_minus,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  input  logic [ebrd_pkg::TS_W-1:0]   in_timestamp_ms,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_sample_valid,
  output logic [SAMPLE_BITS-1:0]      out_sample_out,
  output logic                        out_beat_level,
  output logic                        out_beat_event,
  output logic [ebrd_pkg::RATE_W-1:0] out_rate_q4,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [SAMPLE_BITS-1:0]      cfg_data
);

  ebrd_pkg::ctrl_cmd_t cmd;
  ebrd_pkg::dp_stat_t  stat;

  ebrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ebrd_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_data          (cfg_data),
    .in_leads_off_plus (in_leads_off_plus),
    .in_leads_off_minus(in_leads_off_minus),
    .in_sample         (in_sample),
    .in_timestamp_ms   (in_timestamp_ms),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_sample_valid  (out_sample_valid),
    .out_sample_out    (out_sample_out),
    .out_beat_level    (out_beat_level),
    .out_beat_event    (out_beat_event),
    .out_rate_q4       (out_rate_q4)
  );

endmodule

// ----- src/ebrd_div.sv -----
module ebrd_div #(
  parameter int W = ebrd_pkg::TS_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] quo_nxt;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh  = {rem_r, quo_r[W-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[W-1:0] : rem_sh[W-1:0];
    quo_nxt = {quo_r[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- src/ebrd_dp.sv -----
module ebrd_dp #(
  parameter int HISTORY_DEPTH = ebrd_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = ebrd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ebrd_pkg::ctrl_cmd_t               cmd,
  output ebrd_pkg::dp_stat_t                stat,
  input  logic [SAMPLE_BITS-1:0]            cfg_data,
  input  logic                              in_leads_off_plus,
  input  logic                              in_leads_off_minus,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  input  logic [ebrd_pkg::TS_W-1:0]         in_timestamp_ms,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic                              out_sample_valid,
  output logic [SAMPLE_BITS-1:0]            out_sample_out,
  output logic                              out_beat_level,
  output logic                              out_beat_event,
  output logic [ebrd_pkg::RATE_W-1:0]       out_rate_q4
);

  localparam int TS_W   = ebrd_pkg::TS_W;
  localparam int RATE_W = ebrd_pkg::RATE_W;
  localparam int PW     = 2 * TS_W;
  localparam int REC_SH = $clog2(HISTORY_DEPTH);
  localparam logic [PW-1:0] RECIP =
    ((PW'(1) << (TS_W + REC_SH)) / PW'(HISTORY_DEPTH)) + PW'(1);
  localparam logic [TS_W-1:0] RECIP_LO = RECIP[TS_W-1:0];

  logic [SAMPLE_BITS-1:0] thr_r;
  logic [TS_W-1:0]        beat_times_r [HISTORY_DEPTH];
  logic                   counted_r;
  logic                   trig_r;
  logic [RATE_W-1:0]      rate_r;
  logic                   event_r;

  logic                   off_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [TS_W-1:0]        ts_r;
  logic [TS_W-1:0]        span_r;
  logic [PW-1:0]          prod_r;

  logic                   out_valid_r;
  logic                   out_sample_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_out_r;
  logic                   out_beat_level_r;
  logic                   out_beat_event_r;
  logic [RATE_W-1:0]      out_rate_q4_r;

  logic            at_thr;
  logic            hit;
  logic            rearm;
  logic [TS_W:0]   per_sum;
  logic [TS_W-1:0] period;
  logic            div_done;
  logic [TS_W-1:0] div_quo;

  always_comb begin
    at_thr = (smp_r >= thr_r);
    hit    = !off_r && at_thr && !counted_r;
    rearm  = !off_r && !at_thr;
  end

  // span / depth by reciprocal multiply: multiplier is 2^TS_W plus RECIP_LO
  always_comb begin
    per_sum = {1'b0, span_r} + {1'b0, prod_r[PW-1:TS_W]};
    period  = TS_W'(per_sum >> REC_SH);
  end

  ebrd_div #(
    .W(TS_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(ebrd_pkg::RATE_DIVIDEND),
    .divisor (period),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_comb begin
    stat.rate_go  = hit && (beat_times_r[HISTORY_DEPTH-2] != '0);
    stat.div_done = div_done;
    stat.d_zero   = (period == '0);
    stat.out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off_r <= in_leads_off_plus || in_leads_off_minus;
      smp_r <= in_sample;
      ts_r  <= in_timestamp_ms;
    end
    if (cmd.span_load) begin
      span_r <= ts_r - beat_times_r[HISTORY_DEPTH-2];
    end
    if (cmd.mul_load) begin
      prod_r <= {{TS_W{1'b0}}, span_r} * {{TS_W{1'b0}}, RECIP_LO};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= SAMPLE_BITS'(ebrd_pkg::THR_RESET);
      counted_r <= 1'b0;
      trig_r    <= 1'b0;
      rate_r    <= '0;
      event_r   <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        beat_times_r[i] <= '0;
      end
    end else begin
      if (cmd.cfg_wr) begin
        thr_r <= cfg_data;
      end
      if (cmd.eval) begin
        event_r <= hit;
        if (hit) begin
          counted_r <= 1'b1;
          trig_r    <= 1'b1;
          beat_times_r[0] <= ts_r;
          for (int i = 1; i < HISTORY_DEPTH; i++) begin
            beat_times_r[i] <= beat_times_r[i-1];
          end
        end else if (rearm) begin
          counted_r <= 1'b0;
          trig_r    <= 1'b0;
        end
      end
      if (cmd.rate_sat) begin
        rate_r <= '1;
      end else if (cmd.rate_load) begin
        if (div_quo[TS_W-1:RATE_W] != '0) begin
          rate_r <= '1;
        end else begin
          rate_r <= div_quo[RATE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_sample_valid_r <= !off_r;
      out_sample_out_r   <= off_r ? '0 : smp_r;
      out_beat_level_r   <= trig_r;
      out_beat_event_r   <= event_r;
      out_rate_q4_r      <= rate_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_valid = out_sample_valid_r;
  assign out_sample_out   = out_sample_out_r;
  assign out_beat_level   = out_beat_level_r;
  assign out_beat_event   = out_beat_event_r;
  assign out_rate_q4      = out_rate_q4_r;

endmodule

// ----- src/ebrd_ctrl.sv -----
module ebrd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ebrd_pkg::dp_stat_t  stat,
  output ebrd_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_PER  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cfg_ready  = 1'b1;
        cmd.cfg_wr = cfg_valid;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.rate_go) begin
          cmd.span_load = 1'b1;
          state_nxt     = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_PER;
      end
      S_PER: begin
        if (stat.d_zero) begin
          cmd.rate_sat = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.rate_load = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
